>>> hdl/fqp_pkg.sv
// Shared types, character constants and helpers for the FASTQ record parser.
package fqp_pkg;

    // Characters of interest
    localparam logic [7:0] CH_AT    = 8'h40;  // '@'
    localparam logic [7:0] CH_PLUS  = 8'h2B;  // '+'
    localparam logic [7:0] CH_MINUS = 8'h2D;  // '-'
    localparam logic [7:0] CH_LF    = 8'h0A;  // '\n'
    localparam logic [7:0] CH_TAB   = 8'h09;  // '\t'
    localparam logic [7:0] CH_CR    = 8'h0D;  // '\r'
    localparam logic [7:0] CH_SPACE = 8'h20;  // ' '
    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_C     = 8'h43;
    localparam logic [7:0] CH_G     = 8'h47;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_N     = 8'h4E;
    localparam logic [7:0] LOWER_BIT = 8'h20;

    localparam int unsigned CNT_W = 16;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;
    localparam logic [CNT_W-1:0] MAX_LENGTH_RESET = 16'hFFFF;

    // Register map (word addresses)
    localparam int unsigned PADDR_W = 3;
    localparam logic REG_MAX_LENGTH = 1'b0;

    // Result kinds
    typedef enum logic [2:0] {
        KIND_NAME    = 3'd0,
        KIND_BASE    = 3'd1,
        KIND_QUAL    = 3'd2,
        KIND_REC_END = 3'd3,
        KIND_ERROR   = 3'd4
    } kind_t;

    // Error codes
    typedef enum logic [2:0] {
        ERR_NONE      = 3'd0,
        ERR_NO_HEADER = 3'd1,
        ERR_SEQ_LONG  = 3'd2,
        ERR_QUAL_LONG = 3'd3,
        ERR_MISMATCH  = 3'd4
    } err_t;

    // Parser phase, one-hot
    typedef enum logic [9:0] {
        PH_HEADER     = 10'b00_0000_0001,
        PH_NAME       = 10'b00_0000_0010,
        PH_NAME_SKIP  = 10'b00_0000_0100,
        PH_SEQ_START  = 10'b00_0000_1000,
        PH_SEQ_BODY   = 10'b00_0001_0000,
        PH_SEQ_SKIP   = 10'b00_0010_0000,
        PH_PLUS_LINE  = 10'b00_0100_0000,
        PH_QUAL_START = 10'b00_1000_0000,
        PH_QUAL_BODY  = 10'b01_0000_0000,
        PH_QUAL_SKIP  = 10'b10_0000_0000
    } phase_t;

    // One result word
    typedef struct packed {
        kind_t            kind;
        logic [7:0]       ch;
        logic [CNT_W-1:0] index;
        logic             base_valid;
        logic [CNT_W-1:0] record_length;
        logic             record_good;
        err_t             error_code;
    } result_t;

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_LF) || (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR);
    endfunction

    // Case-insensitive ACGTN check: fold lower case onto upper case
    function automatic logic is_base(input logic [7:0] c);
        logic [7:0] u;
        u = c & ~LOWER_BIT;
        return ((c == u) || (c == (u | LOWER_BIT))) &&
               ((u == CH_A) || (u == CH_C) || (u == CH_G) || (u == CH_T) ||
                (u == CH_N));
    endfunction

endpackage

>>> hdl/fqp_ifs.sv
// Stream interfaces for the FASTQ record parser: text bytes in, results out.
interface fqp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_input;

    modport source (output valid, output in_byte, output end_of_input, input ready);
    modport sink   (input valid, input in_byte, input end_of_input, output ready);
endinterface

interface fqp_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  out_kind;
    logic [7:0]  out_char;
    logic [15:0] char_index;
    logic        base_valid;
    logic [15:0] record_length;
    logic        record_good;
    logic [2:0]  error_code;

    modport source (output valid, output out_kind, output out_char, output char_index,
                    output base_valid, output record_length, output record_good,
                    output error_code, input ready);
    modport sink   (input valid, input out_kind, input out_char, input char_index,
                    input base_valid, input record_length, input record_good,
                    input error_code, output ready);
endinterface

>>> hdl/fastq_record_parser.sv
// Top level of the FASTQ record parser: input stage, parser step, result register.
//
// Usage:
//   in_ch carries one text byte per word (in_byte), or an end-of-file marker
//   (end_of_input = 1, in_byte ignored). out_ch carries at most one result
//   word per input word: name character, base, quality character, record end
//   or error. Both channels use valid/ready; a word moves when both are high.
//   max_length is written over the APB port at byte address 0 (word 0).
// Path: an accepted input word is held in the input register, and its result
//   word is then registered in the result register and presented on out_ch.
// Throughput: one byte per cycle while out_ch keeps taking results; the
//   parser step is a single pass of logic on the phase and the three counters.
// Reset: the parser waits for a header '@', counters are cleared, max_length
//   returns to 65535. After an error word the parser drops every further
//   byte without a result until reset.
// Stall: while out_ch is held, the result register and input register keep
//   their words; in_ch ready drops only when both are occupied.
module fastq_record_parser (
    input  logic                         clk,
    input  logic                         rst_n,
    fqp_in_if.sink                       in_ch,
    fqp_out_if.source                    out_ch,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [fqp_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import fqp_pkg::*;

    logic             s1_valid_reg, s1_valid_next;
    logic [7:0]       s1_byte_reg;
    logic             s1_eoi_reg;
    logic             out_valid_reg, out_valid_next;
    result_t          out_reg;
    logic             fire;
    logic             res_valid;
    result_t          result;
    logic             halted;
    logic [CNT_W-1:0] max_length;

    // Configuration registers
    fqp_apb_regs u_regs (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .max_length (max_length)
    );

    // Input stage handshake: held word moves on when the result slot frees
    assign fire          = s1_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready   = !s1_valid_reg || fire;
    assign s1_valid_next = in_ch.valid || (s1_valid_reg && !fire);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            s1_byte_reg <= in_ch.in_byte;
            s1_eoi_reg  <= in_ch.end_of_input;
        end
    end

    // Parser step
    fqp_step u_step (
        .clk          (clk),
        .rst_n        (rst_n),
        .fire         (fire),
        .in_byte      (s1_byte_reg),
        .end_of_input (s1_eoi_reg),
        .max_length   (max_length),
        .res_valid    (res_valid),
        .result       (result),
        .halted       (halted)
    );

    // Result register
    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ch.ready;
        if (fire)
        begin
            out_valid_next = res_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && res_valid)
        begin
            out_reg <= result;
        end
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.out_kind      = out_reg.kind;
    assign out_ch.out_char      = out_reg.ch;
    assign out_ch.char_index    = out_reg.index;
    assign out_ch.base_valid    = out_reg.base_valid;
    assign out_ch.record_length = out_reg.record_length;
    assign out_ch.record_good   = out_reg.record_good;
    assign out_ch.error_code    = out_reg.error_code;

    // Once halted, the parser stays halted until reset
    assert property (@(posedge clk) disable iff (!rst_n) halted |=> halted)
        else $error("parser left the halted state without reset");

    // Entering halt always comes with an error word in the result register
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(halted) |-> (out_valid_reg && (out_reg.kind == KIND_ERROR)))
        else $error("halt without an error result");

    // A halted parser produces no new result words
    assert property (@(posedge clk) disable iff (!rst_n)
        (halted && !out_valid_reg) |=> !out_valid_reg)
        else $error("result produced while halted");

    // With the result slot empty, input is never refused
    assert property (@(posedge clk) disable iff (!rst_n) !out_valid_reg |-> in_ch.ready)
        else $error("input stalled with an empty result register");
endmodule

>>> hdl/fqp_apb_regs.sv
// APB configuration register block holding max_length.
module fqp_apb_regs (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [fqp_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    output logic [fqp_pkg::CNT_W-1:0]    max_length
);
    import fqp_pkg::*;

    logic [CNT_W-1:0] max_length_reg;
    logic             wr_en;

    // Write strobe in the access phase; byte lanes are ignored
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready && (paddr[2] == REG_MAX_LENGTH);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_length_reg <= MAX_LENGTH_RESET;
        end
        else if (wr_en)
        begin
            max_length_reg <= pwdata[CNT_W-1:0];
        end
    end

    // Read mux
    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_MAX_LENGTH)
        begin
            prdata = {{(32-CNT_W){1'b0}}, max_length_reg};
        end
    end

    assign max_length = max_length_reg;
endmodule

>>> hdl/fqp_step.sv
// Parser state and the single-pass next-state / result logic for one byte.
module fqp_step (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       fire,
    input  logic [7:0]                 in_byte,
    input  logic                       end_of_input,
    input  logic [fqp_pkg::CNT_W-1:0]  max_length,
    output logic                       res_valid,
    output fqp_pkg::result_t           result,
    output logic                       halted
);
    import fqp_pkg::*;

    phase_t           phase_reg,   phase_next;
    logic [CNT_W-1:0] base_reg,    base_next;
    logic [CNT_W-1:0] qual_reg,    qual_next;
    logic [CNT_W-1:0] name_reg,    name_next;
    logic             good_reg,    good_next;
    logic             halted_reg,  halted_next;

    logic             take_seq;
    logic             take_qual;
    logic             c_space;
    logic             c_lf;
    logic             c_base;
    logic             base_over;
    logic             qual_over;
    logic             counts_eq;

    assign c_space   = is_space(in_byte);
    assign c_lf      = (in_byte == CH_LF);
    assign c_base    = is_base(in_byte);
    assign counts_eq = (base_reg == qual_reg);
    // New count reaching the limit is an error
    assign base_over = (({1'b0, base_reg} + 17'd1) >= {1'b0, max_length});
    assign qual_over = (({1'b0, qual_reg} + 17'd1) >= {1'b0, max_length});

    always_comb
    begin
        phase_next  = phase_reg;
        base_next   = base_reg;
        qual_next   = qual_reg;
        name_next   = name_reg;
        good_next   = good_reg;
        halted_next = halted_reg;
        res_valid   = 1'b0;
        result      = '0;
        take_seq    = 1'b0;
        take_qual   = 1'b0;

        if (fire && !halted_reg)
        begin
            if (end_of_input)
            begin
                // End of file: close the record or report a mismatch
                if (phase_reg == PH_HEADER)
                begin
                    res_valid          = 1'b1;
                    result.kind        = KIND_REC_END;
                    result.record_good = 1'b1;
                    base_next = '0;
                    qual_next = '0;
                    name_next = '0;
                    good_next = 1'b1;
                end
                else if (!counts_eq)
                begin
                    res_valid         = 1'b1;
                    result.kind       = KIND_ERROR;
                    result.error_code = ERR_MISMATCH;
                    halted_next       = 1'b1;
                end
                else
                begin
                    res_valid            = 1'b1;
                    result.kind          = KIND_REC_END;
                    result.record_length = base_reg;
                    result.record_good   = good_reg;
                    phase_next = PH_HEADER;
                    base_next  = '0;
                    qual_next  = '0;
                    name_next  = '0;
                    good_next  = 1'b1;
                end
            end
            else
            begin
                unique case (phase_reg)
                    PH_HEADER:
                    begin
                        if (in_byte != CH_AT)
                        begin
                            res_valid         = 1'b1;
                            result.kind       = KIND_ERROR;
                            result.error_code = ERR_NO_HEADER;
                            halted_next       = 1'b1;
                        end
                        else
                        begin
                            base_next  = '0;
                            qual_next  = '0;
                            name_next  = '0;
                            good_next  = 1'b1;
                            phase_next = PH_NAME;
                        end
                    end
                    PH_NAME:
                    begin
                        if (c_space)
                        begin
                            phase_next = c_lf ? PH_SEQ_START : PH_NAME_SKIP;
                        end
                        else
                        begin
                            res_valid    = 1'b1;
                            result.kind  = KIND_NAME;
                            result.ch    = in_byte;
                            result.index = name_reg;
                            if (name_reg != CNT_MAX)
                            begin
                                name_next = name_reg + 1'b1;
                            end
                        end
                    end
                    PH_NAME_SKIP:
                    begin
                        if (c_lf)
                        begin
                            phase_next = PH_SEQ_START;
                        end
                    end
                    PH_SEQ_START:
                    begin
                        if ((in_byte == CH_PLUS) || (in_byte == CH_MINUS))
                        begin
                            phase_next = PH_PLUS_LINE;
                        end
                        else
                        begin
                            take_seq = 1'b1;
                        end
                    end
                    PH_SEQ_BODY:
                    begin
                        take_seq = 1'b1;
                    end
                    PH_SEQ_SKIP:
                    begin
                        if (c_lf)
                        begin
                            phase_next = PH_SEQ_START;
                        end
                    end
                    PH_PLUS_LINE:
                    begin
                        if (c_lf)
                        begin
                            phase_next = PH_QUAL_START;
                        end
                    end
                    PH_QUAL_START:
                    begin
                        if ((in_byte == CH_AT) && counts_eq)
                        begin
                            // Next header: close this record
                            res_valid            = 1'b1;
                            result.kind          = KIND_REC_END;
                            result.record_length = base_reg;
                            result.record_good   = good_reg;
                            phase_next = PH_NAME;
                            base_next  = '0;
                            qual_next  = '0;
                            name_next  = '0;
                            good_next  = 1'b1;
                        end
                        else
                        begin
                            take_qual = 1'b1;
                        end
                    end
                    PH_QUAL_BODY:
                    begin
                        take_qual = 1'b1;
                    end
                    PH_QUAL_SKIP:
                    begin
                        if (c_lf)
                        begin
                            phase_next = PH_QUAL_START;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_HEADER;
                    end
                endcase

                // Sequence character
                if (take_seq)
                begin
                    if (c_space)
                    begin
                        phase_next = c_lf ? PH_SEQ_START : PH_SEQ_SKIP;
                    end
                    else if (base_over)
                    begin
                        res_valid         = 1'b1;
                        result.kind       = KIND_ERROR;
                        result.error_code = ERR_SEQ_LONG;
                        halted_next       = 1'b1;
                    end
                    else
                    begin
                        res_valid         = 1'b1;
                        result.kind       = KIND_BASE;
                        result.ch         = in_byte;
                        result.index      = base_reg;
                        result.base_valid = c_base;
                        base_next  = base_reg + 1'b1;
                        good_next  = good_reg && c_base;
                        phase_next = PH_SEQ_BODY;
                    end
                end

                // Quality character
                if (take_qual)
                begin
                    if (c_space)
                    begin
                        phase_next = c_lf ? PH_QUAL_START : PH_QUAL_SKIP;
                    end
                    else if (qual_over)
                    begin
                        res_valid         = 1'b1;
                        result.kind       = KIND_ERROR;
                        result.error_code = ERR_QUAL_LONG;
                        halted_next       = 1'b1;
                    end
                    else
                    begin
                        res_valid    = 1'b1;
                        result.kind  = KIND_QUAL;
                        result.ch    = in_byte;
                        result.index = qual_reg;
                        qual_next  = qual_reg + 1'b1;
                        phase_next = PH_QUAL_BODY;
                    end
                end
            end
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HEADER;
            base_reg   <= '0;
            qual_reg   <= '0;
            name_reg   <= '0;
            good_reg   <= 1'b1;
            halted_reg <= 1'b0;
        end
        else
        begin
            phase_reg  <= phase_next;
            base_reg   <= base_next;
            qual_reg   <= qual_next;
            name_reg   <= name_next;
            good_reg   <= good_next;
            halted_reg <= halted_next;
        end
    end

    assign halted = halted_reg;
endmodule

>>> sim/tb_top.sv
// Self-checking bench for the FASTQ record parser: directed and random FASTQ text in, results checked.
`timescale 1ns / 1ps

module tb_top;
    import fqp_pkg::*;

    localparam int unsigned WATCHDOG_LIMIT = 5000;
    localparam int unsigned HOLD_CYCLES    = 300;
    localparam int unsigned DRAIN_CYCLES   = 8;
    localparam logic [PADDR_W-1:0] MAX_LENGTH_ADDR = PADDR_W'({REG_MAX_LENGTH, 2'b00});

    typedef enum {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

    // One text word: a byte or an end-of-file marker
    typedef struct packed {
        logic       eof;
        logic [7:0] b;
    } text_word_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    fqp_in_if  in_ch ();
    fqp_out_if out_ch ();

    fastq_record_parser dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Stimulus and expectation stores
    text_word_t  text_bytes[$];
    result_t     predicted_words[$];
    text_word_t  next_word;
    result_t     want;
    int unsigned words_queued = 0;
    int unsigned mismatches = 0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned hold_left;
    int unsigned quiet_cycles = 0;
    logic        hold_trig;

    // Parser shadow state
    phase_t      parse_at = PH_HEADER;
    logic [15:0] n_bases = '0;
    logic [15:0] n_quals = '0;
    logic [15:0] n_names = '0;
    logic        bases_ok = 1'b1;
    logic        halted = 1'b0;
    logic [15:0] max_len_now = MAX_LENGTH_RESET;

    function automatic logic blank_char(input logic [7:0] c);
        return c inside {CH_LF, CH_SPACE, CH_TAB, CH_CR};
    endfunction

    function automatic logic nucleotide(input logic [7:0] c);
        return (c & ~LOWER_BIT) inside {CH_A, CH_C, CH_G, CH_T, CH_N};
    endfunction

    function automatic void restart_counts();
        n_bases  = '0;
        n_quals  = '0;
        n_names  = '0;
        bases_ok = 1'b1;
    endfunction

    // Advance the shadow parser by one text word and queue the result it makes
    function automatic void parse_char(input logic [7:0] c, input logic eof);
        result_t r;
        logic    emit;
        logic    closing;
        r       = '0;
        emit    = 1'b0;
        closing = 1'b0;
        if (!halted) begin
            if (eof) begin
                if (n_bases != n_quals)
                    r.error_code = ERR_MISMATCH;
                else
                    closing = 1'b1;
                parse_at = PH_HEADER;
            end
            else begin
                case (parse_at)
                    PH_NAME:
                        if (blank_char(c))
                            parse_at = (c == CH_LF) ? PH_SEQ_START : PH_NAME_SKIP;
                        else
                        begin
                            r.kind  = KIND_NAME;
                            r.ch    = c;
                            r.index = n_names;
                            emit    = 1'b1;
                            if (n_names != CNT_MAX)
                                n_names = n_names + 16'd1;
                        end
                    PH_NAME_SKIP, PH_SEQ_SKIP:
                        if (c == CH_LF)
                            parse_at = PH_SEQ_START;
                    PH_PLUS_LINE, PH_QUAL_SKIP:
                        if (c == CH_LF)
                            parse_at = PH_QUAL_START;
                    PH_SEQ_START, PH_SEQ_BODY:
                        if (parse_at == PH_SEQ_START && (c == CH_PLUS || c == CH_MINUS))
                            parse_at = PH_PLUS_LINE;
                        else if (blank_char(c))
                            parse_at = (c == CH_LF) ? PH_SEQ_START : PH_SEQ_SKIP;
                        else if ({1'b0, n_bases} + 17'd1 >= {1'b0, max_len_now})
                            r.error_code = ERR_SEQ_LONG;
                        else
                        begin
                            r.kind       = KIND_BASE;
                            r.ch         = c;
                            r.index      = n_bases;
                            r.base_valid = nucleotide(c);
                            bases_ok     = bases_ok & nucleotide(c);
                            n_bases      = n_bases + 16'd1;
                            parse_at     = PH_SEQ_BODY;
                            emit         = 1'b1;
                        end
                    PH_QUAL_START, PH_QUAL_BODY:
                        if (parse_at == PH_QUAL_START && c == CH_AT && n_bases == n_quals)
                        begin
                            closing  = 1'b1;
                            parse_at = PH_NAME;
                        end
                        else if (blank_char(c))
                            parse_at = (c == CH_LF) ? PH_QUAL_START : PH_QUAL_SKIP;
                        else if ({1'b0, n_quals} + 17'd1 >= {1'b0, max_len_now})
                            r.error_code = ERR_QUAL_LONG;
                        else
                        begin
                            r.kind   = KIND_QUAL;
                            r.ch     = c;
                            r.index  = n_quals;
                            n_quals  = n_quals + 16'd1;
                            parse_at = PH_QUAL_BODY;
                            emit     = 1'b1;
                        end
                    default:
                        if (c != CH_AT)
                            r.error_code = ERR_NO_HEADER;
                        else
                        begin
                            restart_counts();
                            parse_at = PH_NAME;
                        end
                endcase
            end
            // record end carries the totals, then counters start over
            if (closing)
            begin
                r.kind          = KIND_REC_END;
                r.record_length = n_bases;
                r.record_good   = bases_ok;
                emit            = 1'b1;
                restart_counts();
            end
            // any error halts the parser for good
            if (r.error_code != ERR_NONE)
            begin
                r.kind = KIND_ERROR;
                halted = 1'b1;
                emit   = 1'b1;
            end
        end
        if (emit)
            predicted_words.push_back(r);
    endfunction

    // Text builders
    function automatic void push_byte(input logic [7:0] b);
        text_bytes.push_back('{1'b0, b});
        words_queued++;
    endfunction

    function automatic void push_eof();
        text_bytes.push_back('{1'b1, 8'($urandom_range(255))});
        words_queued++;
    endfunction

    function automatic logic [7:0] solid_byte();
        logic [7:0] c;
        c = 8'($urandom_range(255));
        while (blank_char(c))
            c = 8'($urandom_range(255));
        return c;
    endfunction

    function automatic logic [7:0] junk_byte();
        logic [7:0] c;
        c = 8'($urandom_range(255));
        return (c == CH_LF) ? CH_SPACE : c;
    endfunction

    function automatic logic [7:0] base_char();
        logic [7:0] letters[10];
        letters = '{"A", "C", "G", "T", "N", "a", "c", "g", "t", "n"};
        if ($urandom_range(0, 4) == 0)
            return solid_byte();
        return letters[$urandom_range(0, 9)];
    endfunction

    // Line ending: plain LF, CRLF, or whitespace and ignored trailing text
    function automatic void end_line();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 2)
            push_byte(CH_CR);
        else if (r < 4)
        begin
            case ($urandom_range(0, 2))
                0:       push_byte(CH_SPACE);
                1:       push_byte(CH_TAB);
                default: push_byte(CH_CR);
            endcase
            repeat ($urandom_range(0, 4))
                push_byte(junk_byte());
        end
        push_byte(CH_LF);
    endfunction

    // One well-formed record with random content and layout
    function automatic void queue_record(input int unsigned cap);
        int unsigned n;
        int unsigned left;
        int unsigned len;
        logic [7:0]  c;
        push_byte(CH_AT);
        repeat ($urandom_range(0, 9))
            push_byte(solid_byte());
        end_line();
        n    = $urandom_range(0, cap);
        left = n;
        while (left != 0)
        begin
            if ($urandom_range(0, 9) == 0)
                push_byte(CH_LF);
            len = $urandom_range(1, (left > 12) ? 12 : left);
            for (int k = 0; k < len; k++)
            begin
                c = base_char();
                while (k == 0 && (c == CH_PLUS || c == CH_MINUS))
                    c = base_char();
                push_byte(c);
            end
            left -= len;
            end_line();
        end
        push_byte($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
        repeat ($urandom_range(0, 3))
            push_byte(junk_byte());
        end_line();
        // qualities: a line may open with '@' while the count is short
        left = n;
        while (left != 0)
        begin
            if ($urandom_range(0, 9) == 0)
                push_byte(CH_LF);
            len = $urandom_range(1, (left > 12) ? 12 : left);
            for (int k = 0; k < len; k++)
                push_byte((k == 0 && $urandom_range(0, 5) == 0) ? CH_AT : solid_byte());
            left -= len;
            end_line();
        end
    endfunction

    function automatic void queue_stream(input int unsigned words, input int unsigned cap);
        int unsigned stop_at;
        int unsigned r;
        stop_at = words_queued + words;
        while (words_queued < stop_at)
        begin
            queue_record(cap);
            r = $urandom_range(0, 9);
            if (r < 2)
                push_eof();
            if (r == 0)
                push_eof();
            if (r == 2)
            begin
                // header with no record behind it, closed by end of file
                push_byte(CH_AT);
                push_eof();
            end
        end
        push_eof();
    endfunction

    task automatic set_idling(input idle_mode_t mode);
        send_idle_pct  = (mode == IDLE_SEND) ? 66 : (mode == IDLE_BOTH) ? 21 : 0;
        recv_stall_pct = (mode == IDLE_RECV) ? 66 : (mode == IDLE_BOTH) ? 21 : 0;
    endtask

    // Wait until every word is in and every result out, then let the pipe empty
    task automatic settle();
        do
            @(negedge clk);
        while (text_bytes.size() != 0 || in_ch.valid || predicted_words.size() != 0);
        repeat (DRAIN_CYCLES)
            @(negedge clk);
    endtask

    // APB write of max_length, then read it back
    task automatic write_max_length(input logic [15:0] v);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= MAX_LENGTH_ADDR;
        pwdata  <= {16'h0, v};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel        <= 1'b0;
        penable     <= 1'b0;
        max_len_now = v;
        @(posedge clk);
        psel   <= 1'b1;
        pwrite <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (prdata[15:0] !== v)
        begin
            $error("max_length readback: expected %0d, got %0d", v, prdata[15:0]);
            mismatches++;
        end
    endtask

    task automatic run_phase(input logic [15:0] ml, input idle_mode_t mode,
                             input int unsigned words, input logic squeeze);
        int unsigned cap;
        cap = (ml - 1 < 30) ? ml - 1 : 30;
        set_idling(mode);
        write_max_length(ml);
        if (squeeze)
        begin
            @(negedge clk);
            hold_trig = 1'b1;
            @(negedge clk);
            hold_trig = 1'b0;
        end
        queue_stream(words, cap);
        settle();
    endtask

    // Clock
    initial
    begin
        clk = 1'b0;
        forever
            #2 clk = ~clk;
    end

    // Input driver: one word per handshake, shadow parser runs on acceptance
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
                parse_char(in_ch.in_byte, in_ch.end_of_input);
            if (!in_ch.valid || in_ch.ready)
            begin
                if (text_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    next_word          = text_bytes.pop_front();
                    in_ch.valid        <= 1'b1;
                    in_ch.in_byte      <= next_word.b;
                    in_ch.end_of_input <= next_word.eof;
                end
                else
                begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_left <= 0;
        else if (hold_trig)
            hold_left <= HOLD_CYCLES;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // Result monitor: compare each accepted word with the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (predicted_words.size() == 0)
                begin
                    $error("unexpected result word: out_kind %0d", out_ch.out_kind);
                    mismatches++;
                end
                else
                begin
                    want = predicted_words.pop_front();
                    if (out_ch.out_kind !== want.kind)
                    begin
                        $error("out_kind: expected %0d, got %0d", want.kind, out_ch.out_kind);
                        mismatches++;
                    end
                    if (out_ch.out_char !== want.ch)
                    begin
                        $error("out_char: expected %0d, got %0d", want.ch, out_ch.out_char);
                        mismatches++;
                    end
                    if (out_ch.char_index !== want.index)
                    begin
                        $error("char_index: expected %0d, got %0d", want.index,
                               out_ch.char_index);
                        mismatches++;
                    end
                    if (out_ch.base_valid !== want.base_valid)
                    begin
                        $error("base_valid: expected %0d, got %0d", want.base_valid,
                               out_ch.base_valid);
                        mismatches++;
                    end
                    if (out_ch.record_length !== want.record_length)
                    begin
                        $error("record_length: expected %0d, got %0d", want.record_length,
                               out_ch.record_length);
                        mismatches++;
                    end
                    if (out_ch.record_good !== want.record_good)
                    begin
                        $error("record_good: expected %0d, got %0d", want.record_good,
                               out_ch.record_good);
                        mismatches++;
                    end
                    if (out_ch.error_code !== want.error_code)
                    begin
                        $error("error_code: expected %0d, got %0d", want.error_code,
                               out_ch.error_code);
                        mismatches++;
                    end
                end
            end
            out_ch.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog: too long without any word moving
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Main sequence
    initial
    begin
        logic [8:0]  directed[];
        err_t        pick;
        logic [7:0]  c;
        int unsigned m;

        rst_n              = 1'b0;
        in_ch.valid        = 1'b0;
        in_ch.in_byte      = 8'h00;
        in_ch.end_of_input = 1'b0;
        out_ch.ready       = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        hold_trig          = 1'b0;
        repeat (11)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: end of file with no header, odd name bytes, valid and invalid
        // bases, '-' separator, '@' taken as a quality, '@' closing a record,
        // an empty record, and a second end of file
        directed = '{9'h100,
                     {1'b0, CH_AT}, 9'h0FF, 9'h000, {1'b0, CH_TAB}, {1'b0, CH_LF},
                     {1'b0, "a"}, {1'b0, "X"}, {1'b0, CH_CR}, {1'b0, CH_LF},
                     {1'b0, CH_MINUS}, {1'b0, CH_LF},
                     {1'b0, CH_AT}, {1'b0, "~"}, {1'b0, CH_LF},
                     {1'b0, CH_AT}, {1'b0, CH_LF}, {1'b0, CH_PLUS}, {1'b0, CH_LF},
                     9'h100, 9'h100};
        set_idling(IDLE_NONE);
        foreach (directed[i])
        begin
            if (directed[i][8])
                push_eof();
            else
                push_byte(directed[i][7:0]);
        end
        settle();

        // Random records across length limits and handshake patterns
        run_phase(16'hFFFF, IDLE_NONE, 120, 1'b1);
        run_phase(16'd2, IDLE_SEND, 120, 1'b0);
        run_phase(16'($urandom_range(3, 24)), IDLE_RECV, 120, 1'b0);
        run_phase(16'hFFFF, IDLE_BOTH, 120, 1'b0);
        run_phase(16'($urandom_range(25, 300)), IDLE_BOTH, 120, 1'b0);
        run_phase(16'($urandom_range(2, 65535)), IDLE_SEND, 120, 1'b0);

        // One error, since it halts the parser for the rest of the run
        set_idling(IDLE_BOTH);
        pick = err_t'($urandom_range(1, 4));
        case (pick)
            ERR_NO_HEADER:
            begin
                c = 8'($urandom_range(255));
                while (c == CH_AT)
                    c = 8'($urandom_range(255));
                push_byte(c);
            end
            ERR_SEQ_LONG:
            begin
                // limit lowered under a record already in progress
                push_byte(CH_AT);
                push_byte("e");
                push_byte(CH_LF);
                push_byte("A");
                push_byte("C");
                settle();
                write_max_length(16'd2);
                push_byte("G");
            end
            ERR_QUAL_LONG:
            begin
                m = $urandom_range(3, 12);
                write_max_length(16'(m));
                push_byte(CH_AT);
                push_byte(CH_LF);
                repeat (m - 1)
                    push_byte("T");
                push_byte(CH_LF);
                push_byte(CH_PLUS);
                push_byte(CH_LF);
                repeat (m + 1)
                    push_byte("I");
            end
            default:
            begin
                push_byte(CH_AT);
                push_byte(CH_LF);
                push_byte("A");
                push_byte("C");
                push_byte(CH_LF);
                push_byte(CH_PLUS);
                push_byte(CH_LF);
                push_byte("I");
                push_eof();
            end
        endcase
        // halted: none of these may produce a word
        repeat (6)
            push_byte(8'($urandom_range(255)));
        push_eof();
        settle();
        write_max_length(16'hFFFF);

        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

>>> filelist.f
hdl/fqp_pkg.sv
hdl/fqp_ifs.sv
hdl/fqp_apb_regs.sv
hdl/fqp_step.sv
hdl/fastq_record_parser.sv
sim/tb_top.sv
